[hw/rtl/pseu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pseu_pkg
// Shared types, codes and helpers of the paired-single execute unit.
// ---------------------------------------------------------------------------
package pseu_pkg;

    // instruction modes
    localparam logic [3:0] MD_MR      = 4'd0;
    localparam logic [3:0] MD_MERGE00 = 4'd1;
    localparam logic [3:0] MD_MERGE01 = 4'd2;
    localparam logic [3:0] MD_MERGE10 = 4'd3;
    localparam logic [3:0] MD_MERGE11 = 4'd4;
    localparam logic [3:0] MD_SUM0    = 4'd5;
    localparam logic [3:0] MD_SUM1    = 4'd6;
    localparam logic [3:0] MD_MULS0   = 4'd7;
    localparam logic [3:0] MD_MULS1   = 4'd8;
    localparam logic [3:0] MD_MADDS0  = 4'd9;
    localparam logic [3:0] MD_MADDS1  = 4'd10;
    localparam logic [3:0] MD_MUL     = 4'd11;
    localparam logic [3:0] MD_MADD    = 4'd12;
    localparam logic [3:0] MD_MSUB    = 4'd13;
    localparam logic [3:0] MD_LOAD    = 4'd14;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FP_UNAV = 2'd1;
    localparam logic [1:0] ST_PROGRAM = 2'd2;

    // configuration register indexes
    localparam logic CFG_FP_AVAIL  = 1'b0;
    localparam logic CFG_PAIRED_EN = 1'b1;

    // binary32 constants
    localparam logic [31:0] DEFAULT_NAN = 32'h7fc0_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [63:0] HIGH_HALF_MASK = 64'hffff_ffff_0000_0000;

    typedef struct packed {
        logic [3:0]  mode;
        logic [4:0]  dest_reg;
        logic [4:0]  src_a_reg;
        logic [4:0]  src_b_reg;
        logic [4:0]  src_c_reg;
        logic [63:0] load_value;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] lane0_value;
        logic [31:0] lane1_value;
    } t_result;

    function automatic logic is_nan32(input logic [31:0] x);
        return x[30:0] > 31'h7f80_0000;
    endfunction

endpackage

[hw/rtl/pseu_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pseu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pseu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/pseu_fpu.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pseu_fpu
// Three-stage binary32 add / multiply, round to nearest even.
// ---------------------------------------------------------------------------
module pseu_fpu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic        i_mul,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_valid,
    output logic [31:0] o_res
);
    import pseu_pkg::*;

    // stage 1 signals
    logic        xs, ys, xinf, yinf, xzero, yzero;
    logic [7:0]  xee, yee;
    logic [23:0] xm, ym;
    logic [47:0] prod;
    logic        swap, bs;
    logic [23:0] bm, sm;
    logic [7:0]  be, se, dd;
    logic [4:0]  dc;
    logic [53:0] al;
    logic [27:0] mx28, my28, sum28;
    logic        n1_spec;
    logic [31:0] n1_bits;
    logic        n1_sign;
    logic signed [10:0] n1_ex;
    logic [47:0] n1_m;

    logic        r1_v, r2_v, r3_v;
    logic        r1_spec, r2_spec;
    logic [31:0] r1_bits, r2_bits, r3_res;
    logic        r1_sign, r2_sign;
    logic signed [10:0] r1_ex, r2_ex;
    logic [47:0] r1_m, r2_m;
    logic        r2_zero;

    // stage 2 signals
    logic [5:0]  lz;
    logic [47:0] n2_m;

    // stage 3 signals
    logic               normal;
    logic signed [10:0] sh_s;
    logic [5:0]         sh;
    logic [95:0]        wide;
    logic [23:0]        q;
    logic               g, st, inc;
    logic [9:0]         ebm1;
    logic [32:0]        total;
    logic [31:0]        n3_res;

    // unpack, specials, multiply or align-and-add
    always_comb begin
        xs    = i_x[31];
        ys    = i_y[31];
        xinf  = (i_x[30:0] == 31'h7f80_0000);
        yinf  = (i_y[30:0] == 31'h7f80_0000);
        xzero = (i_x[30:0] == 31'd0);
        yzero = (i_y[30:0] == 31'd0);
        xm    = {i_x[30:23] != 8'd0, i_x[22:0]};
        ym    = {i_y[30:23] != 8'd0, i_y[22:0]};
        xee   = (i_x[30:23] == 8'd0) ? 8'd1 : i_x[30:23];
        yee   = (i_y[30:23] == 8'd0) ? 8'd1 : i_y[30:23];
        prod  = xm * ym;

        swap  = i_x[30:0] < i_y[30:0];
        bm    = swap ? ym : xm;
        sm    = swap ? xm : ym;
        be    = swap ? yee : xee;
        se    = swap ? xee : yee;
        bs    = swap ? ys : xs;
        dd    = be - se;
        dc    = (dd > 8'd27) ? 5'd27 : dd[4:0];
        al    = {sm, 3'b000, 27'd0} >> dc;
        mx28  = {1'b0, bm, 3'b000};
        my28  = {1'b0, al[53:28], al[27] | (|al[26:0])};
        sum28 = (xs ^ ys) ? (mx28 - my28) : (mx28 + my28);

        n1_spec = 1'b0;
        n1_bits = DEFAULT_NAN;
        if (is_nan32(i_x)) begin
            n1_spec = 1'b1;
            n1_bits = i_x | QUIET_BIT;
        end else if (is_nan32(i_y)) begin
            n1_spec = 1'b1;
            n1_bits = i_y | QUIET_BIT;
        end else if (i_mul) begin
            if (xinf || yinf) begin
                n1_spec = 1'b1;
                n1_bits = (xzero || yzero) ? DEFAULT_NAN : {xs ^ ys, 8'hff, 23'd0};
            end
        end else if (xinf && yinf && (xs != ys)) begin
            n1_spec = 1'b1;
            n1_bits = DEFAULT_NAN;
        end else if (xinf) begin
            n1_spec = 1'b1;
            n1_bits = i_x;
        end else if (yinf) begin
            n1_spec = 1'b1;
            n1_bits = i_y;
        end

        if (i_mul) begin
            n1_sign = xs ^ ys;
            n1_ex   = $signed({3'b000, xee}) + $signed({3'b000, yee}) - 11'sd126;
            n1_m    = prod;
        end else begin
            n1_sign = (sum28 == 28'd0) ? (xs & ys) : bs;
            n1_ex   = $signed({3'b000, be}) + 11'sd1;
            n1_m    = {sum28, 20'd0};
        end
    end

    // leading zero count and left normalize
    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r1_m[i]) begin
                lz = 6'(47 - i);
            end
        end
        n2_m = r1_m << lz;
    end

    // subnormal right shift, round to nearest even, overflow
    always_comb begin
        normal = (r2_ex >= 11'sd1);
        sh_s   = 11'sd1 - r2_ex;
        sh     = normal ? 6'd0 : ((sh_s > 11'sd48) ? 6'd48 : sh_s[5:0]);
        wide   = {r2_m, 48'd0} >> sh;
        q      = wide[95:72];
        g      = wide[71];
        st     = (|wide[70:48]) | (|wide[47:0]);
        inc    = g & (st | q[0]);
        ebm1   = normal ? 10'(r2_ex - 11'sd1) : 10'd0;
        total  = {ebm1, 23'd0} + 33'(q) + 33'(inc);
        if (r2_spec) begin
            n3_res = r2_bits;
        end else if (r2_zero) begin
            n3_res = {r2_sign, 31'd0};
        end else if (total >= {10'd255, 23'd0}) begin
            n3_res = {r2_sign, 8'hff, 23'd0};
        end else begin
            n3_res = {r2_sign, total[30:0]};
        end
    end

    // pipeline valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_go;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r1_spec <= n1_spec;
        r1_bits <= n1_bits;
        r1_sign <= n1_sign;
        r1_ex   <= n1_ex;
        r1_m    <= n1_m;
        r2_spec <= r1_spec;
        r2_bits <= r1_bits;
        r2_sign <= r1_sign;
        r2_ex   <= r1_ex - $signed({5'd0, lz});
        r2_m    <= n2_m;
        r2_zero <= (r1_m == 48'd0);
        r3_res  <= n3_res;
    end

    assign o_valid = r3_v;
    assign o_res   = r3_res;
endmodule

[hw/rtl/paired_single_execute_unit_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// paired_single_execute_unit_core
// Paired-single instruction execution on a RAM-based register file.
// ---------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_item and raise i_start; the instruction is taken
//   at a clock edge with i_start high and o_busy low. o_busy stays high until
//   the result is produced.
//   Result channel: o_done pulses for one cycle with o_result; it cannot be
//   held off by the receiver.
//   Configuration channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data; write only while the unit is idle.
// Sequence (accept to o_done): loads and exceptions go straight to write-back;
//   every other mode first does three sequential reads of the single-read-port
//   register RAM, then moves and merges write back, sums and multiplies pass
//   the three-stage add/multiply unit once and multiply-adds pass it twice.
//   The next instruction can be accepted in the cycle o_done is high.
// Reset: synchronous, active low; every register reads as zero and both
//   configuration bits are cleared. Per-entry valid bits cover the RAM, so
//   there is no clearing pass.
// ---------------------------------------------------------------------------
module paired_single_execute_unit_core #(
    parameter int REG_COUNT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  pseu_pkg::t_item   i_item,
    output logic              o_done,
    output pseu_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data
);
    import pseu_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RDB   = 10'b00_0000_0010,
        S_RDC   = 10'b00_0000_0100,
        S_CAPC  = 10'b00_0000_1000,
        S_EXEC  = 10'b00_0001_0000,
        S_MULGO = 10'b00_0010_0000,
        S_MULW  = 10'b00_0100_0000,
        S_ADDGO = 10'b00_1000_0000,
        S_ADDW  = 10'b01_0000_0000,
        S_WB    = 10'b10_0000_0000
    } t_state;

    t_state      r_state;
    t_item       r_item;
    logic [1:0]  r_status;
    logic        r_fp_avail, r_paired_en;
    logic [63:0] r_a, r_b, r_c;
    logic [31:0] r_p0, r_p1, r_res0, r_res1;
    logic        r_rd_vld;
    logic        r_valid [REG_COUNT];
    logic        r_done;
    t_result     r_result;

    logic [AW-1:0] w_mod [32];
    logic [AW-1:0] raddr, waddr;
    logic          we;
    logic [63:0]   rdata, opnd;
    logic [1:0]    acc_status;

    logic        fpu_go, fpu_mul, v0, v1;
    logic [31:0] x0, y0, x1, y1, f0, f1;
    logic [31:0] a0, a1, b0, b1, c0, c1, csel0, csel1, bneg0, bneg1;
    logic [32:0] fix0, fix1;
    logic        is_madd;

    // register index folding onto the file depth
    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign w_mod[g] = AW'(g % REG_COUNT);
    end

    // fold NaN operands in a, b, c order for the multiply-adds
    function automatic logic [32:0] nan_pick(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        logic [32:0] r;
        r = 33'd0;
        if (is_nan32(a)) begin
            r = {1'b1, a | QUIET_BIT};
        end else if (is_nan32(b)) begin
            r = {1'b1, b | QUIET_BIT};
        end else if (is_nan32(c)) begin
            r = {1'b1, c | QUIET_BIT};
        end
        return r;
    endfunction

    // register file RAM
    pseu_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_rf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({r_res0, r_res1}),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // read address sequencing and unwritten entries read as zero
    always_comb begin
        case (r_state)
            S_RDB:   raddr = w_mod[r_item.src_b_reg];
            S_RDC:   raddr = w_mod[r_item.src_c_reg];
            default: raddr = w_mod[i_item.src_a_reg];
        endcase
        opnd  = r_rd_vld ? rdata : 64'd0;
        waddr = w_mod[r_item.dest_reg];
        we    = (r_state == S_WB) && (r_status == ST_DONE);
    end

    // exception check at accept
    always_comb begin
        if (i_item.mode == MD_LOAD) begin
            acc_status = ST_DONE;
        end else if (i_item.mode > MD_LOAD) begin
            acc_status = ST_PROGRAM;
        end else if (!r_fp_avail) begin
            acc_status = ST_FP_UNAV;
        end else if (!r_paired_en) begin
            acc_status = ST_PROGRAM;
        end else begin
            acc_status = ST_DONE;
        end
    end

    // lane operands
    always_comb begin
        a0 = r_a[63:32];
        a1 = r_a[31:0];
        b0 = r_b[63:32];
        b1 = r_b[31:0];
        c0 = r_c[63:32];
        c1 = r_c[31:0];
        case (r_item.mode) inside
            MD_MULS0, MD_MADDS0: begin
                csel0 = c0;
                csel1 = c0;
            end
            MD_MULS1, MD_MADDS1: begin
                csel0 = c1;
                csel1 = c1;
            end
            default: begin
                csel0 = c0;
                csel1 = c1;
            end
        endcase
        bneg0   = (r_item.mode == MD_MSUB) ? (b0 ^ SIGN_BIT) : b0;
        bneg1   = (r_item.mode == MD_MSUB) ? (b1 ^ SIGN_BIT) : b1;
        is_madd = (r_item.mode == MD_MADDS0) || (r_item.mode == MD_MADDS1) ||
                  (r_item.mode == MD_MADD) || (r_item.mode == MD_MSUB);
        fpu_mul = (r_state == S_MULGO);
        fpu_go  = (r_state == S_MULGO) || (r_state == S_ADDGO);
        if (fpu_mul) begin
            x0 = a0;
            y0 = csel0;
            x1 = a1;
            y1 = csel1;
        end else if (is_madd) begin
            x0 = r_p0;
            y0 = bneg0;
            x1 = r_p1;
            y1 = bneg1;
        end else begin
            x0 = a0;
            y0 = b1;
            x1 = a1;
            y1 = b1;
        end
        fix0 = nan_pick(a0, b0, csel0);
        fix1 = nan_pick(a1, b1, csel1);
    end

    // one arithmetic unit per lane
    pseu_fpu u_fpu0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (fpu_go),
        .i_mul   (fpu_mul),
        .i_x     (x0),
        .i_y     (y0),
        .o_valid (v0),
        .o_res   (f0)
    );

    pseu_fpu u_fpu1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (fpu_go),
        .i_mul   (fpu_mul),
        .i_x     (x1),
        .i_y     (y1),
        .o_valid (v1),
        .o_res   (f1)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_fp_avail  <= 1'b0;
            r_paired_en <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FP_AVAIL) begin
                    r_fp_avail <= i_cfg_data;
                end else begin
                    r_paired_en <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if ((i_item.mode == MD_LOAD) || (acc_status != ST_DONE)) begin
                            r_state <= S_WB;
                        end else begin
                            r_state <= S_RDB;
                        end
                    end
                end
                S_RDB:   r_state <= S_RDC;
                S_RDC:   r_state <= S_CAPC;
                S_CAPC:  r_state <= S_EXEC;
                S_EXEC: begin
                    case (r_item.mode) inside
                        MD_SUM0, MD_SUM1: r_state <= S_ADDGO;
                        [MD_MULS0:MD_MSUB]: r_state <= S_MULGO;
                        default: r_state <= S_WB;
                    endcase
                end
                S_MULGO: r_state <= S_MULW;
                S_MULW: begin
                    if (v0 && v1) begin
                        r_state <= is_madd ? S_ADDGO : S_WB;
                    end
                end
                S_ADDGO: r_state <= S_ADDW;
                S_ADDW: begin
                    if (v0 && v1) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_status == ST_DONE) begin
                        r_valid[waddr] <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[raddr];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_item   <= i_item;
                    r_status <= acc_status;
                    if ((i_item.mode == MD_LOAD) && (acc_status == ST_DONE)) begin
                        r_res0 <= 32'((i_item.load_value & HIGH_HALF_MASK) >> 32);
                        r_res1 <= i_item.load_value[31:0];
                    end else begin
                        r_res0 <= 32'd0;
                        r_res1 <= 32'd0;
                    end
                end
            end
            S_RDB:  r_a <= opnd;
            S_RDC:  r_b <= opnd;
            S_CAPC: r_c <= opnd;
            S_EXEC: begin
                case (r_item.mode)
                    MD_MR: begin
                        r_res0 <= b0;
                        r_res1 <= b1;
                    end
                    MD_MERGE00: begin
                        r_res0 <= a0;
                        r_res1 <= b0;
                    end
                    MD_MERGE01: begin
                        r_res0 <= a0;
                        r_res1 <= b1;
                    end
                    MD_MERGE10: begin
                        r_res0 <= a1;
                        r_res1 <= b0;
                    end
                    MD_MERGE11: begin
                        r_res0 <= a1;
                        r_res1 <= b1;
                    end
                    default: begin
                        r_res0 <= r_res0;
                        r_res1 <= r_res1;
                    end
                endcase
            end
            S_MULW: begin
                if (v0 && v1) begin
                    r_p0   <= f0;
                    r_p1   <= f1;
                    r_res0 <= f0;
                    r_res1 <= f1;
                end
            end
            S_ADDW: begin
                if (v0 && v1) begin
                    if (r_item.mode == MD_SUM0) begin
                        r_res0 <= f0;
                        r_res1 <= c1;
                    end else if (r_item.mode == MD_SUM1) begin
                        r_res0 <= c0;
                        r_res1 <= f0;
                    end else begin
                        r_res0 <= fix0[32] ? fix0[31:0] : f0;
                        r_res1 <= fix1[32] ? fix1[31:0] : f1;
                    end
                end
            end
            S_WB: begin
                r_result.status      <= r_status;
                r_result.lane0_value <= r_res0;
                r_result.lane1_value <= r_res1;
            end
            default: begin
                r_res0 <= r_res0;
            end
        endcase
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for paired_single_execute_unit_core. A directed table
// of instructions (special floats, every mode, disabled states) runs first,
// then random instruction streams under three idling profiles. Every result
// is checked against a behavioral model of the register file and binary32
// arithmetic kept in the bench.
// ---------------------------------------------------------------------------
module testbench;
    import pseu_pkg::*;

    localparam logic [3:0] MD_ILLEGAL = 4'd15;
    localparam int N_RANDOM = 1200;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    logic    o_busy;
    t_item   i_item;
    logic    o_done;
    t_result o_result;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    logic    i_cfg_index;
    logic    i_cfg_data;

    paired_single_execute_unit_core #(.REG_COUNT(32)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_item(i_item), .o_done(o_done), .o_result(o_result),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // bench copy of the unit state
    logic [63:0] pair_regs [32];
    logic        fp_on;
    logic        ps_on;
    t_result     pending_results [$];
    int          mismatch_count;
    int          gap_pct;

    typedef struct {
        logic    fp;
        logic    pe;
        t_item   item;
        logic    has_exp;
        t_result exp;
    } dir_row_t;

    dir_row_t dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // binary32 helpers
    function automatic logic f32_nan(input logic [31:0] x);
        return (x & 32'h7fff_ffff) > 32'h7f80_0000;
    endfunction

    function automatic real f32_to_real(input logic [31:0] x);
        logic [7:0]  e;
        logic [22:0] m;
        real         v;
        e = x[30:23];
        m = x[22:0];
        if (e == 8'hff) v = $bitstoreal({1'b0, 11'h7ff, 52'd0});
        else if (e == 8'd0) v = real'(m) * (2.0 ** -149);
        else v = $bitstoreal({1'b0, 11'(int'(e) - 127 + 1023), m, 29'd0});
        return x[31] ? -v : v;
    endfunction

    // round a double to binary32, nearest even; host NaN gives the default NaN
    function automatic logic [31:0] real_to_f32(input real v);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] r;
        int          ex;
        int          k;
        d = $realtobits(v);
        ex = int'(d[62:52]) - 1023;
        if (d[62:52] == 11'h7ff)
            return (d[51:0] != 0) ? DEFAULT_NAN : {d[63], 31'h7f80_0000};
        if (d[62:52] == 11'd0) return {d[63], 31'd0};
        if (ex > 127) return {d[63], 31'h7f80_0000};
        sig = {11'd0, 1'b1, d[51:0]};
        if (ex >= -126) begin
            k = 29;
            q = {33'd0, 8'(ex + 127), d[51:29]};
        end else begin
            k = -97 - ex;
            if (k > 60) return {d[63], 31'd0};
            q = sig >> k;
        end
        rem = sig & ((64'd1 << k) - 1);
        half = 64'd1 << (k - 1);
        if (rem > half || (rem == half && q[0])) q = q + 1;
        r = {d[63], q[30:0]};
        return r;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        if (f32_nan(a)) return a | QUIET_BIT;
        if (f32_nan(b)) return b | QUIET_BIT;
        return real_to_f32(f32_to_real(a) + f32_to_real(b));
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] c);
        if (f32_nan(a)) return a | QUIET_BIT;
        if (f32_nan(c)) return c | QUIET_BIT;
        return real_to_f32(f32_to_real(a) * f32_to_real(c));
    endfunction

    function automatic logic [31:0] fp_madd(input logic [31:0] a, input logic [31:0] c,
                                            input logic [31:0] b, input logic neg);
        if (f32_nan(a)) return a | QUIET_BIT;
        if (f32_nan(b)) return b | QUIET_BIT;
        if (f32_nan(c)) return c | QUIET_BIT;
        return fp_add(fp_mul(a, c), neg ? (b ^ SIGN_BIT) : b);
    endfunction

    // executes one instruction on the bench register file
    function automatic t_result execute_instr(input t_item it);
        logic [31:0] a0, a1, b0, b1, c0, c1, r0, r1;
        logic [1:0]  st;
        a0 = pair_regs[it.src_a_reg][63:32];
        a1 = pair_regs[it.src_a_reg][31:0];
        b0 = pair_regs[it.src_b_reg][63:32];
        b1 = pair_regs[it.src_b_reg][31:0];
        c0 = pair_regs[it.src_c_reg][63:32];
        c1 = pair_regs[it.src_c_reg][31:0];
        r0 = '0;
        r1 = '0;
        st = ST_DONE;
        if (it.mode == MD_LOAD) begin
            r0 = it.load_value[63:32];
            r1 = it.load_value[31:0];
        end else if (it.mode == MD_ILLEGAL) st = ST_PROGRAM;
        else if (!fp_on) st = ST_FP_UNAV;
        else if (!ps_on) st = ST_PROGRAM;
        else begin
            case (it.mode)
                MD_MR:      begin r0 = b0; r1 = b1; end
                MD_MERGE00: begin r0 = a0; r1 = b0; end
                MD_MERGE01: begin r0 = a0; r1 = b1; end
                MD_MERGE10: begin r0 = a1; r1 = b0; end
                MD_MERGE11: begin r0 = a1; r1 = b1; end
                MD_SUM0:    begin r0 = fp_add(a0, b1); r1 = c1; end
                MD_SUM1:    begin r0 = c0; r1 = fp_add(a0, b1); end
                MD_MULS0:   begin r0 = fp_mul(a0, c0); r1 = fp_mul(a1, c0); end
                MD_MULS1:   begin r0 = fp_mul(a0, c1); r1 = fp_mul(a1, c1); end
                MD_MADDS0: begin
                    r0 = fp_madd(a0, c0, b0, 1'b0);
                    r1 = fp_madd(a1, c0, b1, 1'b0);
                end
                MD_MADDS1: begin
                    r0 = fp_madd(a0, c1, b0, 1'b0);
                    r1 = fp_madd(a1, c1, b1, 1'b0);
                end
                MD_MUL:     begin r0 = fp_mul(a0, c0); r1 = fp_mul(a1, c1); end
                MD_MADD: begin
                    r0 = fp_madd(a0, c0, b0, 1'b0);
                    r1 = fp_madd(a1, c1, b1, 1'b0);
                end
                default: begin
                    r0 = fp_madd(a0, c0, b0, 1'b1);
                    r1 = fp_madd(a1, c1, b1, 1'b1);
                end
            endcase
        end
        if (st == ST_DONE) pair_regs[it.dest_reg] = {r0, r1};
        return '{status: st, lane0_value: r0, lane1_value: r1};
    endfunction

    function automatic t_item mk_item(input logic [3:0] md, input int d, input int a,
                                      input int b, input int c, input logic [63:0] lv);
        return '{mode: md, dest_reg: 5'(d), src_a_reg: 5'(a), src_b_reg: 5'(b),
                 src_c_reg: 5'(c), load_value: lv};
    endfunction

    task automatic add_row(input logic fp, input logic pe, input t_item it,
                           input logic chk, input t_result ex);
        dir_row_t r;
        r = '{fp: fp, pe: pe, item: it, has_exp: chk, exp: ex};
        dir_rows.push_back(r);
    endtask

    // random binary32 operand, biased toward special values
    function automatic logic [31:0] rand_f32();
        case ($urandom_range(0, 9))
            0: return 32'h7f80_0000 | ($urandom_range(0, 1) << 31);
            1: return $urandom_range(0, 1) << 31;
            2: return {$urandom_range(0, 1) == 1, 8'hff, 23'($urandom)};
            3: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
            4: return {$urandom_range(0, 1) == 1, 8'($urandom_range(1, 254)), 23'($urandom)};
            5: return 32'h7f7f_ffff | ($urandom_range(0, 1) << 31);
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 154)),
                             23'($urandom)};
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    span;
        span = ($urandom_range(0, 3) == 0) ? 31 : 7;
        it.mode = ($urandom_range(0, 19) == 0) ? MD_ILLEGAL :
                  ($urandom_range(0, 3) == 0) ? MD_LOAD : 4'($urandom_range(0, 13));
        it.dest_reg  = 5'($urandom_range(0, span));
        it.src_a_reg = 5'($urandom_range(0, span));
        it.src_b_reg = 5'($urandom_range(0, span));
        it.src_c_reg = 5'($urandom_range(0, span));
        if (it.mode == MD_LOAD && $urandom_range(0, 3) != 0)
            it.load_value = {rand_f32(), rand_f32()};
        else
            it.load_value = {$urandom, $urandom};
        return it;
    endfunction

    // one instruction transaction; i_start stays high unless a gap is drawn
    // a typed expectation, when given, is held against the bench model and queued
    task automatic issue_instr(input t_item it, input logic chk, input t_result ex);
        t_result want;
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        want = execute_instr(it);
        if (chk) begin
            if (want !== ex) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("table row: typed %0d %h %h, bench model %0d %h %h",
                             ex.status, ex.lane0_value, ex.lane1_value,
                             want.status, want.lane0_value, want.lane1_value);
            end
            want = ex;
        end
        pending_results.push_back(want);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // drain, then write both configuration registers
    task automatic set_config(input logic fp, input logic pe);
        int guard;
        i_start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (16) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_FP_AVAIL;
        i_cfg_data  <= fp;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PAIRED_EN;
        i_cfg_data  <= pe;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        fp_on = fp;
        ps_on = pe;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d lanes %h %h",
                             o_result.status, o_result.lane0_value, o_result.lane1_value);
            end else begin
                want = pending_results.pop_front();
                if (o_result.status !== want.status
                    || o_result.lane0_value !== want.lane0_value
                    || o_result.lane1_value !== want.lane1_value) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d %h %h, got %0d %h %h",
                                 want.status, want.lane0_value, want.lane1_value,
                                 o_result.status, o_result.lane0_value,
                                 o_result.lane1_value);
                end
            end
        end
    end

    // run limit
    initial begin
        #4ms;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        int       ix;
        int       guard;
        dir_row_t r;
        mismatch_count = 0;
        gap_pct = 19;
        fp_on = 1'b0;
        ps_on = 1'b0;
        for (ix = 0; ix < 32; ix++) pair_regs[ix] = '0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FP_AVAIL;
        i_cfg_data = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: disabled states, special operands, every mode
        add_row(0, 0, mk_item(MD_MR, 5, 0, 0, 0, '0), 1, '{ST_FP_UNAV, 0, 0});
        add_row(0, 0, mk_item(MD_LOAD, 1, 0, 0, 0, 64'h7f800000_00000000), 1,
                '{ST_DONE, 32'h7f800000, 0});
        add_row(0, 0, mk_item(MD_ILLEGAL, 31, 31, 31, 31, '1), 1, '{ST_PROGRAM, 0, 0});
        add_row(1, 0, mk_item(MD_MR, 5, 1, 1, 1, '0), 1, '{ST_PROGRAM, 0, 0});
        add_row(1, 0, mk_item(MD_ILLEGAL, 5, 1, 1, 1, '0), 1, '{ST_PROGRAM, 0, 0});
        add_row(1, 1, mk_item(MD_LOAD, 2, 0, 0, 0, 64'h7f800001_80000000), 1,
                '{ST_DONE, 32'h7f800001, 32'h80000000});
        add_row(1, 1, mk_item(MD_LOAD, 3, 0, 0, 0, 64'h3f800000_40000000), 1,
                '{ST_DONE, 32'h3f800000, 32'h40000000});
        add_row(1, 1, mk_item(MD_LOAD, 4, 0, 0, 0, 64'h7f7fffff_00000001), 1,
                '{ST_DONE, 32'h7f7fffff, 32'h00000001});
        add_row(1, 1, mk_item(MD_LOAD, 7, 0, 0, 0, 64'hff800000_ff800000), 1,
                '{ST_DONE, 32'hff800000, 32'hff800000});
        add_row(1, 1, mk_item(MD_LOAD, 31, 0, 0, 0, '1), 1, '{ST_DONE, '1, '1});
        add_row(1, 1, mk_item(MD_MR, 5, 0, 3, 0, '0), 1,
                '{ST_DONE, 32'h3f800000, 32'h40000000});
        add_row(1, 1, mk_item(MD_MERGE00, 6, 3, 4, 0, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MERGE01, 6, 3, 4, 0, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MERGE10, 6, 3, 4, 0, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MERGE11, 6, 3, 4, 0, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_SUM0, 8, 1, 1, 3, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_SUM1, 8, 1, 7, 3, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MULS0, 9, 1, 0, 0, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MULS1, 9, 4, 0, 4, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MADDS0, 10, 2, 3, 3, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MADDS1, 10, 3, 4, 3, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MUL, 11, 4, 0, 4, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MADD, 12, 3, 31, 3, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MSUB, 13, 3, 3, 3, '0), 0, '{0, 0, 0});
        add_row(1, 1, mk_item(MD_MSUB, 3, 3, 4, 4, '0), 0, '{0, 0, 0});

        foreach (dir_rows[ix]) begin
            r = dir_rows[ix];
            if (r.fp !== fp_on || r.pe !== ps_on) set_config(r.fp, r.pe);
            issue_instr(r.item, r.has_exp, r.exp);
        end

        // random streams under three idling profiles
        for (ix = 0; ix < N_RANDOM; ix++) begin
            if (ix == N_RANDOM / 3) gap_pct = 63;
            if (ix == 2 * N_RANDOM / 3) gap_pct = 0;
            if (ix % 150 == 0)
                case ($urandom_range(0, 5))
                    0: set_config(1'b0, 1'($urandom_range(0, 1)));
                    1: set_config(1'b1, 1'b0);
                    default: set_config(1'b1, 1'b1);
                endcase
            issue_instr(rand_item(), 1'b0, '0);
        end
        i_start <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
